FILE: hw/rtl/urs_pkg.sv
// ----------------------------------------------------------------------------
// urs_pkg
// Shared types, constants and register codes of the ultrasonic ranger
// sequencer.
// ----------------------------------------------------------------------------
package urs_pkg;

	localparam int NUM_SENSORS_DEF     = 2;
	localparam int ECHO_COUNT_BITS_DEF = 16;

	localparam int PIN_BITS     = 2;
	localparam int PIN_IDX_BITS = 1;
	localparam int DIST_BITS    = 14;
	localparam int TICK_BITS    = 17;
	localparam int TRIG_W_BITS  = 10;
	localparam int SPEED_BITS   = 9;

	localparam int DIV_PRESHIFT = 4;
	localparam int DIV_ODD      = 125;

	localparam int APB_ADDR_BITS = 5;
	localparam int APB_DATA_BITS = 32;
	localparam int REG_IDX_BITS  = 3;

	localparam int IN_TDATA_BITS  = 8;
	localparam int OUT_TDATA_BITS = 24;
	localparam int OUT_TUSER_BITS = 2;

	localparam logic [REG_IDX_BITS-1:0] REG_TRIGGER_WIDTH = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_ECHO_TIMEOUT  = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_ROUND_GAP     = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_MIN_DISTANCE  = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_MAX_DISTANCE  = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_SOUND_SPEED   = 3'd5;

	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	typedef enum logic [1:0] {
		PH_TRIGGER = 2'd0,
		PH_WAIT    = 2'd1,
		PH_GAP     = 2'd2
	} phase_t;

	typedef struct packed {
		logic [TRIG_W_BITS-1:0] trigger_width_us;
		logic [TICK_BITS-1:0]   echo_timeout_us;
		logic [TICK_BITS-1:0]   round_gap_us;
		logic [DIST_BITS-1:0]   min_distance_mm;
		logic [DIST_BITS-1:0]   max_distance_mm;
		logic [SPEED_BITS-1:0]  sound_speed;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		trigger_width_us: 10'd20,
		echo_timeout_us:  17'd70000,
		round_gap_us:     17'd60000,
		min_distance_mm:  14'd20,
		max_distance_mm:  14'd3910,
		sound_speed:      9'd340
	};

	typedef struct packed {
		logic [PIN_BITS-1:0] trigger_levels;
		logic                distance_valid;
		logic                measured_sensor;
		logic                timed_out;
	} meas_info_t;

	typedef struct packed {
		logic [PIN_BITS-1:0]  trigger_levels;
		logic                 distance_valid;
		logic                 measured_sensor;
		logic [DIST_BITS-1:0] range_mm;
		logic                 timed_out;
	} result_t;

endpackage

FILE: hw/rtl/urs_cfg_regs.sv
// ----------------------------------------------------------------------------
// urs_cfg_regs
// APB register file holding the timing, clamp and sound speed settings.
// ----------------------------------------------------------------------------
module urs_cfg_regs import urs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output cfg_t                     cfg
);

	cfg_t                    cfg_q;
	logic                    wr_en;
	logic [REG_IDX_BITS-1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[APB_ADDR_BITS-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_TRIGGER_WIDTH: cfg_q.trigger_width_us <= pwdata[TRIG_W_BITS-1:0];
				REG_ECHO_TIMEOUT:  cfg_q.echo_timeout_us  <= pwdata[TICK_BITS-1:0];
				REG_ROUND_GAP:     cfg_q.round_gap_us     <= pwdata[TICK_BITS-1:0];
				REG_MIN_DISTANCE:  cfg_q.min_distance_mm  <= pwdata[DIST_BITS-1:0];
				REG_MAX_DISTANCE:  cfg_q.max_distance_mm  <= pwdata[DIST_BITS-1:0];
				REG_SOUND_SPEED:   cfg_q.sound_speed      <= pwdata[SPEED_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TRIGGER_WIDTH: prdata = APB_DATA_BITS'(cfg_q.trigger_width_us);
			REG_ECHO_TIMEOUT:  prdata = APB_DATA_BITS'(cfg_q.echo_timeout_us);
			REG_ROUND_GAP:     prdata = APB_DATA_BITS'(cfg_q.round_gap_us);
			REG_MIN_DISTANCE:  prdata = APB_DATA_BITS'(cfg_q.min_distance_mm);
			REG_MAX_DISTANCE:  prdata = APB_DATA_BITS'(cfg_q.max_distance_mm);
			REG_SOUND_SPEED:   prdata = APB_DATA_BITS'(cfg_q.sound_speed);
			default:           prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/urs_ctrl.sv
// ----------------------------------------------------------------------------
// urs_ctrl
// Input register, sensor sequencing state machine and echo counter; forms
// the raw echo product for the distance stage.
// ----------------------------------------------------------------------------
module urs_ctrl import urs_pkg::*; #(
	parameter int NUM_SENSORS     = NUM_SENSORS_DEF,
	parameter int ECHO_COUNT_BITS = ECHO_COUNT_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cfg_t                                  cfg,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [PIN_BITS-1:0]                   echo_levels,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output meas_info_t                            out_info,
	output logic [ECHO_COUNT_BITS+SPEED_BITS-1:0] out_prod
);

	localparam int SENSOR_BITS = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
	localparam int PROD_BITS   = ECHO_COUNT_BITS + SPEED_BITS;
	localparam logic [ECHO_COUNT_BITS-1:0] ECHO_MAX = '1;

	logic                       valid_s1;
	logic [PIN_BITS-1:0]        echo_s1;
	logic                       valid_s2;
	meas_info_t                 info_s2;
	logic [PROD_BITS-1:0]       prod_s2;

	phase_t                     phase_q, phase_d;
	logic [SENSOR_BITS-1:0]     sensor_q, sensor_d;
	logic [TICK_BITS-1:0]       ticks_q, ticks_d;
	logic [ECHO_COUNT_BITS-1:0] echo_ticks_q, echo_ticks_d;
	logic                       echo_prev_q, echo_prev_d;
	logic                       started_q, started_d;

	logic                       ready_s2;
	logic                       fire_s1;
	logic                       echo_c;
	logic                       done_c;
	logic                       last_sensor;
	logic [PIN_BITS-1:0]        trig_c;
	logic [TICK_BITS-1:0]       ticks_inc;
	logic [TRIG_W_BITS-1:0]     width_eff;
	logic [TICK_BITS-1:0]       limit_eff;
	meas_info_t                 info_c;
	logic [PROD_BITS-1:0]       prod_c;

	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s2;
	assign fire_s1  = valid_s1 && ready_s2;

	assign out_valid = valid_s2;
	assign out_info  = info_s2;
	assign out_prod  = prod_s2;

	assign echo_c      = (int'(sensor_q) < PIN_BITS) ? echo_s1[sensor_q[PIN_IDX_BITS-1:0]] : 1'b0;
	assign trig_c      = PIN_BITS'(1) << sensor_q;
	assign last_sensor = (sensor_q == SENSOR_BITS'(NUM_SENSORS - 1));
	assign ticks_inc   = ticks_q + TICK_BITS'(1);
	assign width_eff   = (cfg.trigger_width_us == '0) ? TRIG_W_BITS'(1) : cfg.trigger_width_us;
	assign limit_eff   = (cfg.echo_timeout_us == '0) ? TICK_BITS'(1) : cfg.echo_timeout_us;
	assign prod_c      = PROD_BITS'(echo_ticks_q) * PROD_BITS'(cfg.sound_speed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			echo_s1 <= echo_levels;
		end
		if (ready_s2) begin
			info_s2 <= info_c;
			prod_s2 <= prod_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_TRIGGER;
			sensor_q     <= '0;
			ticks_q      <= '0;
			echo_ticks_q <= '0;
			echo_prev_q  <= 1'b0;
			started_q    <= 1'b0;
		end else if (fire_s1) begin
			phase_q      <= phase_d;
			sensor_q     <= sensor_d;
			ticks_q      <= ticks_d;
			echo_ticks_q <= echo_ticks_d;
			echo_prev_q  <= echo_prev_d;
			started_q    <= started_d;
		end
	end

	always_comb begin
		phase_d      = phase_q;
		sensor_d     = sensor_q;
		ticks_d      = ticks_q;
		echo_ticks_d = echo_ticks_q;
		echo_prev_d  = echo_prev_q;
		started_d    = started_q;
		done_c       = 1'b0;
		info_c       = '0;
		unique case (phase_q)
			PH_TRIGGER: begin
				info_c.trigger_levels = trig_c;
				ticks_d = ticks_inc;
				if (ticks_inc >= TICK_BITS'(width_eff)) begin
					phase_d      = PH_WAIT;
					ticks_d      = '0;
					echo_ticks_d = '0;
					echo_prev_d  = 1'b0;
					started_d    = 1'b0;
				end
			end
			PH_WAIT: begin
				if (echo_c) begin
					if (!echo_prev_q) begin
						started_d    = 1'b1;
						echo_ticks_d = ECHO_COUNT_BITS'(1);
					end else if (echo_ticks_q != ECHO_MAX) begin
						echo_ticks_d = echo_ticks_q + ECHO_COUNT_BITS'(1);
					end
				end else if (echo_prev_q && started_q) begin
					info_c.distance_valid  = 1'b1;
					info_c.measured_sensor = sensor_q[0];
					done_c = 1'b1;
				end
				echo_prev_d = echo_c;
				if (!done_c) begin
					ticks_d = ticks_inc;
					if (ticks_inc >= limit_eff) begin
						info_c.distance_valid  = 1'b1;
						info_c.measured_sensor = sensor_q[0];
						info_c.timed_out       = 1'b1;
						done_c = 1'b1;
					end
				end
				if (done_c) begin
					ticks_d = '0;
					if (last_sensor) begin
						sensor_d = '0;
						phase_d  = (cfg.round_gap_us == '0) ? PH_TRIGGER : PH_GAP;
					end else begin
						sensor_d = sensor_q + SENSOR_BITS'(1);
						phase_d  = PH_TRIGGER;
					end
				end
			end
			PH_GAP: begin
				ticks_d = ticks_inc;
				if (ticks_inc >= cfg.round_gap_us) begin
					phase_d = PH_TRIGGER;
					ticks_d = '0;
				end
			end
			default: begin
				phase_d = PH_TRIGGER;
				ticks_d = '0;
			end
		endcase
	end

endmodule

FILE: hw/rtl/urs_dist.sv
// ----------------------------------------------------------------------------
// urs_dist
// Distance stage: divides the echo product by 2000 with a reciprocal
// multiply, clamps it and holds the result in the output register.
// ----------------------------------------------------------------------------
module urs_dist import urs_pkg::*; #(
	parameter int ECHO_COUNT_BITS = ECHO_COUNT_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cfg_t                                  cfg,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  meas_info_t                            in_info,
	input  logic [ECHO_COUNT_BITS+SPEED_BITS-1:0] in_prod,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output result_t                               out_result
);

	localparam int PROD_BITS  = ECHO_COUNT_BITS + SPEED_BITS;
	localparam int NUM_BITS   = PROD_BITS - DIV_PRESHIFT;
	localparam int RECIP_SHIFT = NUM_BITS + 7;
	localparam int MUL_BITS   = 2 * NUM_BITS + 1;
	localparam int QUOT_BITS  = MUL_BITS - RECIP_SHIFT;
	localparam int CMP_BITS   = (QUOT_BITS > DIST_BITS) ? QUOT_BITS : DIST_BITS;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << RECIP_SHIFT) + 64'(DIV_ODD - 1)) / 64'(DIV_ODD);
	localparam logic [NUM_BITS:0] RECIP = RECIP_FULL[NUM_BITS:0];

	logic                 valid_s3;
	result_t              result_s3;
	logic [NUM_BITS-1:0]  scaled_c;
	logic [MUL_BITS-1:0]  mul_c;
	logic [QUOT_BITS-1:0] quot_c;
	logic [CMP_BITS-1:0]  quot_w;
	logic [DIST_BITS-1:0] clamped_c;
	result_t              result_c;

	assign in_ready   = !valid_s3 || out_ready;
	assign out_valid  = valid_s3;
	assign out_result = result_s3;

	assign scaled_c = in_prod[PROD_BITS-1:DIV_PRESHIFT];
	assign mul_c    = MUL_BITS'(scaled_c) * MUL_BITS'(RECIP);
	assign quot_c   = mul_c[MUL_BITS-1:RECIP_SHIFT];
	assign quot_w   = CMP_BITS'(quot_c);

	always_comb begin
		priority if (quot_w < CMP_BITS'(cfg.min_distance_mm)) begin
			clamped_c = cfg.min_distance_mm;
		end else if (quot_w > CMP_BITS'(DIST_MAX)) begin
			clamped_c = DIST_MAX;
		end else begin
			clamped_c = quot_w[DIST_BITS-1:0];
		end
	end

	always_comb begin
		result_c.trigger_levels  = in_info.trigger_levels;
		result_c.distance_valid  = in_info.distance_valid;
		result_c.measured_sensor = in_info.measured_sensor;
		result_c.timed_out       = in_info.timed_out;
		priority if (in_info.timed_out) begin
			result_c.range_mm = cfg.max_distance_mm;
		end else if (in_info.distance_valid) begin
			result_c.range_mm = clamped_c;
		end else begin
			result_c.range_mm = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			result_s3 <= result_c;
		end
	end

endmodule

FILE: hw/rtl/ultrasonic_ranger_sequencer.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranger_sequencer
// Round-robin ultrasonic echo ranging sequencer.
//
// Each slave beat is one microsecond tick carrying the echo pin levels of
// all sensors; each master beat is the matching result: trigger pin drive,
// and on a completed measurement the sensor index, distance in mm and the
// timeout flag. Exactly one master beat leaves for every slave beat.
// Settings must be written over the APB port while the block is idle; it does not enforce this.
// A slave beat passes the input register, product register and output
// register on its way to master tvalid. Throughput is one beat per cycle
// while no stall holds the output; the sequencer state is updated from its
// registered value as each beat leaves the input register, and the divide
// by 2000 is a reciprocal multiply in the stage after the echo product.
// Reset loads the default settings, restarts at the trigger of sensor 0
// and empties the pipeline. When m_tready is low the output beat holds,
// the stages behind it fill, then s_tready drops; state advances only as
// beats move.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_sequencer import urs_pkg::*; #(
	parameter int NUM_SENSORS     = NUM_SENSORS_DEF,
	parameter int ECHO_COUNT_BITS = ECHO_COUNT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_BITS-1:0]  paddr,
	input  logic [APB_DATA_BITS-1:0]  pwdata,
	output logic [APB_DATA_BITS-1:0]  prdata,
	output logic                      pready,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// [1:0] echo_levels, [7:2] zero
	input  logic [IN_TDATA_BITS-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// [1:0] trigger_levels, [2] measured_sensor, [16:3] range_mm, [23:17] zero
	output logic [OUT_TDATA_BITS-1:0] m_tdata,
	// [0] distance_valid, [1] timed_out
	output logic [OUT_TUSER_BITS-1:0] m_tuser
);

	localparam int PROD_BITS = ECHO_COUNT_BITS + SPEED_BITS;

	cfg_t                 cfg;
	logic                 valid_s2;
	logic                 ready_s2;
	meas_info_t           info_s2;
	logic [PROD_BITS-1:0] prod_s2;
	result_t              result;

	urs_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	urs_ctrl #(
		.NUM_SENSORS     (NUM_SENSORS),
		.ECHO_COUNT_BITS (ECHO_COUNT_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.echo_levels (s_tdata[PIN_BITS-1:0]),
		.out_valid   (valid_s2),
		.out_ready   (ready_s2),
		.out_info    (info_s2),
		.out_prod    (prod_s2)
	);

	urs_dist #(
		.ECHO_COUNT_BITS (ECHO_COUNT_BITS)
	) u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (valid_s2),
		.in_ready   (ready_s2),
		.in_info    (info_s2),
		.in_prod    (prod_s2),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	assign m_tdata = OUT_TDATA_BITS'({result.range_mm, result.measured_sensor,
		result.trigger_levels});
	assign m_tuser = {result.timed_out, result.distance_valid};

	a_meas_no_trigger: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && info_s2.distance_valid |-> info_s2.trigger_levels == '0)
		else $error("trigger driven on a measurement beat");

	a_timeout_is_meas: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && info_s2.timed_out |-> info_s2.distance_valid)
		else $error("timeout flagged without a completed measurement");

	a_one_trigger: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[PIN_BITS-1:0]))
		else $error("more than one trigger driven");

endmodule

FILE: sim/ranger_checker.sv
// ----------------------------------------------------------------------------
// ranger_checker
// Tracks the settings written over APB, runs its own ranging sequencer on
// every tick beat taken by the block, and matches each output beat field by
// field against the oldest expected result.
// ----------------------------------------------------------------------------
module ranger_checker import urs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic                      pready,
	input  logic [APB_ADDR_BITS-1:0]  paddr,
	input  logic [APB_DATA_BITS-1:0]  pwdata,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [IN_TDATA_BITS-1:0]  s_tdata,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [OUT_TDATA_BITS-1:0] m_tdata,
	input  logic [OUT_TUSER_BITS-1:0] m_tuser,
	output int                        mismatches,
	output int                        pending,
	output int                        n_ticks,
	output int                        n_meas,
	output int                        n_tout
);
	timeunit 1ns;
	timeprecision 1ps;

	// round trip and m/s to mm/us scaling
	localparam logic [31:0] ROUND_TRIP_DIV = 32'd2000;

	cfg_t                           cfg;
	phase_t                         ph;
	logic [PIN_IDX_BITS-1:0]        sensor;
	logic [TICK_BITS-1:0]           ph_ticks;
	logic [ECHO_COUNT_BITS_DEF-1:0] echo_cnt;
	logic                           echo_last;
	logic                           echo_seen;
	result_t                        range_q[$];

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("[%0t] result %0d: %s is %0d, expected %0d", $time, n_ticks, field, got,
			want);
		mismatches++;
	endtask

	function automatic void advance_sensor();
		ph_ticks = '0;
		if (int'(sensor) + 1 >= NUM_SENSORS_DEF) begin
			sensor = '0;
			ph = (cfg.round_gap_us == '0) ? PH_TRIGGER : PH_GAP;
		end else begin
			sensor = sensor + 1'b1;
			ph = PH_TRIGGER;
		end
	endfunction

	function automatic result_t range_tick(input logic [PIN_BITS-1:0] echo);
		result_t              r;
		logic [TICK_BITS-1:0] limit;
		logic                 lvl;
		logic                 done;
		logic [31:0]          calc_mm;
		r = '0;
		case (ph)
			PH_TRIGGER: begin
				limit = (cfg.trigger_width_us == '0) ? TICK_BITS'(1) :
					TICK_BITS'(cfg.trigger_width_us);
				r.trigger_levels = PIN_BITS'(1) << sensor;
				ph_ticks = ph_ticks + 1'b1;
				if (ph_ticks >= limit) begin
					ph = PH_WAIT;
					ph_ticks = '0;
					echo_cnt = '0;
					echo_last = 1'b0;
					echo_seen = 1'b0;
				end
			end
			PH_WAIT: begin
				limit = (cfg.echo_timeout_us == '0) ? TICK_BITS'(1) : cfg.echo_timeout_us;
				lvl = echo[sensor];
				done = 1'b0;
				if (lvl) begin
					if (!echo_last) begin
						echo_seen = 1'b1;
						echo_cnt = '0;
					end
					if (echo_cnt != '1)
						echo_cnt = echo_cnt + 1'b1;
				end else if (echo_last && echo_seen) begin
					calc_mm = 32'(echo_cnt) * 32'(cfg.sound_speed) / ROUND_TRIP_DIV;
					if (calc_mm < 32'(cfg.min_distance_mm))
						calc_mm = 32'(cfg.min_distance_mm);
					if (calc_mm > 32'(DIST_MAX))
						calc_mm = 32'(DIST_MAX);
					r.distance_valid = 1'b1;
					r.measured_sensor = sensor;
					r.range_mm = calc_mm[DIST_BITS-1:0];
					done = 1'b1;
				end
				echo_last = lvl;
				if (!done) begin
					ph_ticks = ph_ticks + 1'b1;
					if (ph_ticks >= limit) begin
						r.distance_valid = 1'b1;
						r.measured_sensor = sensor;
						r.range_mm = cfg.max_distance_mm;
						r.timed_out = 1'b1;
						done = 1'b1;
					end
				end
				if (done)
					advance_sensor();
			end
			PH_GAP: begin
				ph_ticks = ph_ticks + 1'b1;
				if (ph_ticks >= cfg.round_gap_us) begin
					ph = PH_TRIGGER;
					ph_ticks = '0;
				end
			end
			default: begin
				ph = PH_TRIGGER;
				ph_ticks = '0;
			end
		endcase
		return r;
	endfunction

	task automatic write_setting(input logic [REG_IDX_BITS-1:0] idx,
		input logic [APB_DATA_BITS-1:0] val);
		case (idx)
			REG_TRIGGER_WIDTH: cfg.trigger_width_us = val[TRIG_W_BITS-1:0];
			REG_ECHO_TIMEOUT:  cfg.echo_timeout_us = val[TICK_BITS-1:0];
			REG_ROUND_GAP:     cfg.round_gap_us = val[TICK_BITS-1:0];
			REG_MIN_DISTANCE:  cfg.min_distance_mm = val[DIST_BITS-1:0];
			REG_MAX_DISTANCE:  cfg.max_distance_mm = val[DIST_BITS-1:0];
			REG_SOUND_SPEED:   cfg.sound_speed = val[SPEED_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic check_beat();
		result_t got;
		result_t want;
		got.trigger_levels = m_tdata[1:0];
		got.measured_sensor = m_tdata[2];
		got.range_mm = m_tdata[16:3];
		got.distance_valid = m_tuser[0];
		got.timed_out = m_tuser[1];
		if (range_q.size() == 0) begin
			report_mismatch("beat with nothing expected", 1, 0);
			return;
		end
		want = range_q.pop_front();
		n_ticks++;
		if (got.trigger_levels !== want.trigger_levels)
			report_mismatch("trigger_levels", got.trigger_levels, want.trigger_levels);
		if (got.distance_valid !== want.distance_valid)
			report_mismatch("distance_valid", got.distance_valid, want.distance_valid);
		if (got.measured_sensor !== want.measured_sensor)
			report_mismatch("measured_sensor", got.measured_sensor, want.measured_sensor);
		if (got.range_mm !== want.range_mm)
			report_mismatch("range_mm", got.range_mm, want.range_mm);
		if (got.timed_out !== want.timed_out)
			report_mismatch("timed_out", got.timed_out, want.timed_out);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = CFG_RESET;
			ph = PH_TRIGGER;
			sensor = '0;
			ph_ticks = '0;
			echo_cnt = '0;
			echo_last = 1'b0;
			echo_seen = 1'b0;
			range_q.delete();
			mismatches = 0;
			pending = 0;
			n_ticks = 0;
			n_meas = 0;
			n_tout = 0;
		end else begin
			if (psel && penable && pwrite && pready)
				write_setting(paddr[APB_ADDR_BITS-1:2], pwdata);
			if (m_tvalid && m_tready)
				check_beat();
			if (s_tvalid && s_tready) begin
				range_q.push_back(range_tick(s_tdata[PIN_BITS-1:0]));
				if (range_q[$].timed_out)
					n_tout++;
				else if (range_q[$].distance_valid)
					n_meas++;
			end
			pending = range_q.size();
		end
	end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives microsecond tick beats of echo levels into the ranging sequencer:
// default settings, echoes already high at wait start, zero settings, short
// echoes under a high minimum, then rounds of random echo pulse trains under
// random settings, most of them with stalls on both sides.
// ----------------------------------------------------------------------------
module testbench import urs_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 200;
	localparam int ROUNDS       = 8;
	localparam int ROUND_TICKS  = 36;

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [APB_ADDR_BITS-1:0]  paddr;
	logic [APB_DATA_BITS-1:0]  pwdata;
	logic [APB_DATA_BITS-1:0]  prdata;
	logic                      pready;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [IN_TDATA_BITS-1:0]  s_tdata;   // [1:0] echo_levels, [7:2] zero
	logic                      m_tvalid;
	logic                      m_tready;
	logic [OUT_TDATA_BITS-1:0] m_tdata;   // [1:0] trigger_levels, [2] measured_sensor,
	                                      // [16:3] range_mm, [23:17] zero
	logic [OUT_TUSER_BITS-1:0] m_tuser;   // [0] distance_valid, [1] timed_out

	int   mismatches;
	int   pending;
	int   n_ticks;
	int   n_meas;
	int   n_tout;
	int   cycles;
	logic tx_idle_on;
	logic rx_idle_on;
	logic hold_req;
	logic hold_done;
	logic [PIN_BITS-1:0] echo_lvl;
	int   echo_left[PIN_BITS];

	ultrasonic_ranger_sequencer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	ranger_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.pending    (pending),
		.n_ticks    (n_ticks),
		.n_meas     (n_meas),
		.n_tout     (n_tout)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int idle_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		int n;
		m_tready <= 1'b0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				m_tready <= 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				n = idle_len();
				repeat (n) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_tick(input logic [PIN_BITS-1:0] echo);
		int n;
		if (tx_idle_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			n = idle_len();
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_BITS'(echo);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_run(input int n, input logic [PIN_BITS-1:0] echo);
		repeat (n) send_tick(echo);
	endtask

	// pulse trains per sensor with random high and low lengths, plus some noise
	task automatic send_pulses(input int n);
		logic [PIN_BITS-1:0] echo;
		repeat (n) begin
			for (int s = 0; s < PIN_BITS; s++) begin
				if (echo_left[s] == 0) begin
					echo_lvl[s] = ~echo_lvl[s];
					echo_left[s] = echo_lvl[s] ? $urandom_range(1, 20) : $urandom_range(1, 12);
				end
				echo_left[s]--;
			end
			echo = echo_lvl;
			if ($urandom_range(0, 99) < 10)
				echo = PIN_BITS'($urandom_range(0, 3));
			send_tick(echo);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input logic [REG_IDX_BITS-1:0] idx,
		input logic [APB_DATA_BITS-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(input int trig_w, input int timeout, input int gap,
		input int min_mm, input int max_mm, input int speed);
		reg_write(REG_TRIGGER_WIDTH, trig_w);
		reg_write(REG_ECHO_TIMEOUT, timeout);
		reg_write(REG_ROUND_GAP, gap);
		reg_write(REG_MIN_DISTANCE, min_mm);
		reg_write(REG_MAX_DISTANCE, max_mm);
		reg_write(REG_SOUND_SPEED, speed);
	endtask

	initial begin
		int min_mm;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		hold_req = 1'b0;
		echo_lvl = '0;
		for (int s = 0; s < PIN_BITS; s++)
			echo_left[s] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default settings: echo during trigger is ignored, then quiet wait
		send_run(20, 2'b11);
		send_run(5, 2'b00);
		drain();

		// echo already high at wait start on both sensors, clamped to the minimum
		load_settings(2, 120, 3, 50, 0, 400);
		send_run(2, 2'b11);
		send_run(60, 2'b01);
		send_run(1, 2'b00);
		send_run(2, 2'b11);
		send_run(5, 2'b10);
		send_run(1, 2'b00);
		send_pulses(20);
		drain();

		// zero trigger width and timeout act as one, a zero gap skips the gap: every wait ends in a timeout
		load_settings(0, 0, 0, 0, 13107, 300);
		send_pulses(12);
		drain();

		// short echoes clamped up to a minimum of 13107 mm
		load_settings(1, 20, 0, 13107, 0, 300);
		send_pulses(25);
		drain();

		for (int r = 0; r < ROUNDS; r++) begin
			min_mm = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 80) :
				$urandom_range(0, 13107);
			load_settings($urandom_range(0, 3), $urandom_range(0, 40), $urandom_range(0, 4),
				min_mm, $urandom_range(0, 13107), $urandom_range(300, 400));
			tx_idle_on = (r % 3 != 2);
			rx_idle_on = (r % 3 != 2);
			if (r == 2)
				hold_req = 1'b1;
			if (r == 4) begin
				send_pulses(ROUND_TICKS / 2);
				drain();
				send_pulses(ROUND_TICKS / 2);
			end else begin
				send_pulses(ROUND_TICKS);
			end
			drain();
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("checked %0d tick results: %0d echo measurements, %0d timeouts",
			n_ticks, n_meas, n_tout);
		$display("covered echoes high at wait start, zero settings, %0d random rounds",
			ROUNDS);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
